/* rtl/core/biph_pkg.sv */
// ----------------------------------------------------------------------------
// biph_pkg
// Shared types and constants for the biphase tape frame encoder.
// ----------------------------------------------------------------------------
package biph_pkg;

  // address width of the header start and end addresses
  localparam int ADDRESS_BITS = 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register reset values
  localparam logic [7:0]  PILOT_BITS_RST  = 8'd247;
  localparam logic [7:0]  HIGH_LEVEL_RST  = 8'hB0;
  localparam logic [7:0]  LOW_LEVEL_RST   = 8'h50;
  localparam logic [15:0] HALFWAVE_RST    = 16'd417;

  // sync trailer bytes
  localparam logic [7:0] TRAIL_BYTE0 = 8'h00;
  localparam logic [7:0] TRAIL_BYTE2 = 8'hE6;

  // input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // register indexes
  localparam logic [7:0] REG_PILOT_BITS = 8'd0;
  localparam logic [7:0] REG_HIGH_LEVEL = 8'd1;
  localparam logic [7:0] REG_LOW_LEVEL  = 8'd2;
  localparam logic [7:0] REG_HALFWAVE   = 8'd3;

  // segment codes
  typedef enum logic [2:0] {
    SEG_PILOT   = 3'd0,
    SEG_HEADER  = 3'd1,
    SEG_DATA    = 3'd2,
    SEG_TRAILER = 3'd3,
    SEG_CHECK   = 3'd4
  } seg_t;

  // frame phases
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_t;

  // one unit of work for the back end: a pilot cell, or a byte with an
  // optional sync trailer behind it
  typedef struct packed {
    logic       pilot;
    logic [7:0] data;
    seg_t       seg;
    logic       trailer;
    logic       done;
    logic [7:0] rep;
  } job_t;

endpackage

/* rtl/core/biph_queue.sv */
// ----------------------------------------------------------------------------
// biph_queue
// Short job queue between the classifying front end and the cell back end.
// ----------------------------------------------------------------------------
module biph_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  biph_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output biph_pkg::job_t  head_job,
  output logic            head_valid
);

  localparam int PW = biph_pkg::QPTR_W;
  localparam int CW = $clog2(biph_pkg::QUEUE_DEPTH + 1);

  biph_pkg::job_t entry_r [biph_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full       = (count_r == CW'(biph_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(biph_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(biph_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/core/biph_front.sv */
// ----------------------------------------------------------------------------
// biph_front
// Accepts input words, tracks the frame phase and the address window, and
// turns each word into a job for the back end.
// ----------------------------------------------------------------------------
module biph_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_op,
  input  logic [7:0]      in_byte,
  input  logic [7:0]      pilot_bits,
  input  logic            q_full,
  output logic            q_push,
  output biph_pkg::job_t  q_job
);

  localparam int AW = biph_pkg::ADDRESS_BITS;

  biph_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       bcnt_r, bcnt_nxt;
  logic [AW:0]      addr_r, addr_nxt;
  logic [AW-1:0]    end_r, end_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [AW-1:0]    asm_addr;
  logic [AW:0]      addr_inc;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign asm_addr = AW'({in_byte, hold_r});
  assign addr_inc = addr_r + 1'b1;

  // classify the word and step the frame state
  always_comb begin
    phase_nxt   = phase_r;
    bcnt_nxt    = bcnt_r;
    addr_nxt    = addr_r;
    end_nxt     = end_r;
    hold_nxt    = hold_r;
    q_push      = 1'b0;
    q_job.pilot   = 1'b0;
    q_job.data    = in_byte;
    q_job.seg     = biph_pkg::SEG_HEADER;
    q_job.trailer = 1'b0;
    q_job.done    = 1'b0;
    q_job.rep     = 8'd1;
    if (accept) begin
      if (in_op == biph_pkg::OP_START) begin
        phase_nxt   = biph_pkg::PH_HEADER;
        bcnt_nxt    = '0;
        addr_nxt    = '0;
        end_nxt     = '0;
        hold_nxt    = '0;
        q_push      = (pilot_bits != 8'd0);
        q_job.pilot = 1'b1;
        q_job.data  = 8'd0;
        q_job.seg   = biph_pkg::SEG_PILOT;
        q_job.rep   = pilot_bits;
      end else begin
        case (phase_r)
          biph_pkg::PH_HEADER: begin
            q_push    = 1'b1;
            q_job.seg = biph_pkg::SEG_HEADER;
            case (bcnt_r)
              2'd0, 2'd2: begin
                hold_nxt = in_byte;
                bcnt_nxt = bcnt_r + 1'b1;
              end
              2'd1: begin
                addr_nxt = {1'b0, asm_addr};
                bcnt_nxt = 2'd2;
              end
              default: begin
                end_nxt  = asm_addr;
                bcnt_nxt = '0;
                // empty data run goes straight to the trailer
                if (addr_r > {1'b0, asm_addr}) begin
                  q_job.trailer = 1'b1;
                  phase_nxt     = biph_pkg::PH_CHECK;
                end else begin
                  phase_nxt = biph_pkg::PH_DATA;
                end
              end
            endcase
          end
          biph_pkg::PH_DATA: begin
            q_push    = 1'b1;
            q_job.seg = biph_pkg::SEG_DATA;
            addr_nxt  = addr_inc;
            if (addr_inc > {1'b0, end_r}) begin
              q_job.trailer = 1'b1;
              phase_nxt     = biph_pkg::PH_CHECK;
              bcnt_nxt      = '0;
            end
          end
          biph_pkg::PH_CHECK: begin
            q_push    = 1'b1;
            q_job.seg = biph_pkg::SEG_CHECK;
            if (bcnt_r == 2'd0) begin
              bcnt_nxt = 2'd1;
            end else begin
              q_job.done = 1'b1;
              phase_nxt  = biph_pkg::PH_IDLE;
              bcnt_nxt   = '0;
            end
          end
          default: begin
            phase_nxt = biph_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= biph_pkg::PH_IDLE;
      bcnt_r  <= '0;
      addr_r  <= '0;
      end_r   <= '0;
      hold_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      addr_r  <= addr_nxt;
      end_r   <= end_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

/* rtl/core/biph_back.sv */
// ----------------------------------------------------------------------------
// biph_back
// Expands queued jobs into biphase bit cells, one cell per cycle while the
// receiver is ready, MSB first, into a registered output stage.
// ----------------------------------------------------------------------------
module biph_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  biph_pkg::job_t  head_job,
  output logic            q_pop,
  input  logic [7:0]      high_level,
  input  logic [7:0]      low_level,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_bit,
  output logic [7:0]      out_first,
  output logic [7:0]      out_second,
  output logic [7:0]      out_rep,
  output biph_pkg::seg_t  out_seg,
  output logic            out_last,
  output logic            out_done
);

  logic [4:0]     idx_r, idx_nxt;
  logic           valid_r;
  logic           bit_r;
  logic [7:0]     first_r, second_r, rep_r;
  biph_pkg::seg_t seg_r;
  logic           last_r, done_r;

  logic [7:0]     cur_byte;
  logic           cur_bit;
  logic           cur_last;
  biph_pkg::seg_t cur_seg;
  logic [7:0]     cur_rep;
  logic           load;

  // pick the byte being sent: job byte, then trailer 00 00 E6
  always_comb begin
    case (idx_r[4:3])
      2'd0:    cur_byte = head_job.data;
      2'd3:    cur_byte = biph_pkg::TRAIL_BYTE2;
      default: cur_byte = biph_pkg::TRAIL_BYTE0;
    endcase
  end

  // cell fields for the current index
  always_comb begin
    if (head_job.pilot) begin
      cur_bit  = 1'b0;
      cur_seg  = biph_pkg::SEG_PILOT;
      cur_rep  = head_job.rep;
      cur_last = 1'b1;
    end else begin
      cur_bit  = cur_byte[3'd7 - idx_r[2:0]];
      cur_seg  = (idx_r[4:3] == 2'd0) ? head_job.seg : biph_pkg::SEG_TRAILER;
      cur_rep  = 8'd1;
      cur_last = (idx_r == 5'd7 && !head_job.trailer) || (idx_r == 5'd31);
    end
  end

  assign load    = head_valid && (!valid_r || out_ready);
  assign q_pop   = load && cur_last;
  assign idx_nxt = q_pop ? 5'd0 : (load ? idx_r + 1'b1 : idx_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load) begin
      bit_r    <= cur_bit;
      first_r  <= cur_bit ? low_level : high_level;
      second_r <= cur_bit ? high_level : low_level;
      rep_r    <= cur_rep;
      seg_r    <= cur_seg;
      last_r   <= cur_last;
      done_r   <= cur_last && head_job.done;
    end
  end

  assign out_valid  = valid_r;
  assign out_bit    = bit_r;
  assign out_first  = first_r;
  assign out_second = second_r;
  assign out_rep    = rep_r;
  assign out_seg    = seg_r;
  assign out_last   = last_r;
  assign out_done   = done_r;

endmodule

/* rtl/core/biphase_tape_frame_encoder_core.sv */
// ----------------------------------------------------------------------------
// biphase_tape_frame_encoder_core
// Biphase tape frame encoder: pilot, header, data, sync trailer and checksum
// bytes turned into bit cells with their half-wave amplitudes.
//
//   channel  dir  handshake            payload
//   in_      in   tvalid/tready        tdata = data_byte, tuser = opcode
//   out_     out  tvalid/tready/tlast  tdata = cell, tuser = segment, done
//   cfg_     in   we                   index, wdata (16 bits)
//
// A byte word gives 8 cells, one per cycle while the output is taken; a byte
// that closes the data run, or a last header byte that finds the run empty,
// gives 32 cells (its own plus the 00 00 E6 trailer); one with no frame open
// gives none. A start word gives one pilot cell, or none when the pilot
// length is zero. The cell back end sets the rate; the front end classifies
// the next word while the back end is still busy, through a two-entry queue.
// Reset is synchronous; a stalled output holds the queue and then the input.
// ----------------------------------------------------------------------------
module biphase_tape_frame_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] bit_value, [8:1] first_level,
                                  // [16:9] second_level, [24:17] repeat_count
  output logic [3:0]  out_tuser,  // [2:0] segment, [3] frame_done
  output logic        out_tlast,  // last_in_run
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [7:0]  pilot_bits_r;
  logic [7:0]  high_level_r;
  logic [7:0]  low_level_r;
  logic [15:0] halfwave_r;

  logic           q_full, q_push, q_pop, q_valid;
  biph_pkg::job_t q_in_job, q_head_job;

  logic           c_bit, c_last, c_done;
  logic [7:0]     c_first, c_second, c_rep;
  biph_pkg::seg_t c_seg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pilot_bits_r <= biph_pkg::PILOT_BITS_RST;
      high_level_r <= biph_pkg::HIGH_LEVEL_RST;
      low_level_r  <= biph_pkg::LOW_LEVEL_RST;
      halfwave_r   <= biph_pkg::HALFWAVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        biph_pkg::REG_PILOT_BITS: pilot_bits_r <= cfg_wdata[7:0];
        biph_pkg::REG_HIGH_LEVEL: high_level_r <= cfg_wdata[7:0];
        biph_pkg::REG_LOW_LEVEL:  low_level_r  <= cfg_wdata[7:0];
        biph_pkg::REG_HALFWAVE:   halfwave_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front end
  biph_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_byte    (in_tdata),
    .pilot_bits (pilot_bits_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_in_job)
  );

  // job queue
  biph_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_job   (q_head_job),
    .head_valid (q_valid)
  );

  // cell back end
  biph_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (q_head_job),
    .q_pop      (q_pop),
    .high_level (high_level_r),
    .low_level  (low_level_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_bit    (c_bit),
    .out_first  (c_first),
    .out_second (c_second),
    .out_rep    (c_rep),
    .out_seg    (c_seg),
    .out_last   (c_last),
    .out_done   (c_done)
  );

  // output packing
  assign out_tdata = {7'd0, c_rep, c_second, c_first, c_bit};
  assign out_tuser = {c_done, c_seg};
  assign out_tlast = c_last;

endmodule

/* tb/sv/biph_frame_checker.sv */
// ----------------------------------------------------------------------------
// biph_frame_checker
// Watches the byte, cell and register ports of the biphase tape frame
// encoder, predicts the bit cells of every accepted byte word and compares
// each accepted cell word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module biph_frame_checker
  import biph_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  // one predicted bit cell
  typedef struct {
    logic       bit_value;
    logic [7:0] first_level;
    logic [7:0] second_level;
    logic [7:0] repeat_count;
    seg_t       seg;
    logic       last_in_run;
    logic       frame_done;
  } cell_t;

  cell_t cells_due[$];
  int    bad_words = 0;
  int    due_cnt   = 0;

  // register copies
  logic [7:0]  pilot_len;
  logic [7:0]  amp_high;
  logic [7:0]  amp_low;
  logic [15:0] halfwave_us;

  // frame tracking
  phase_t                frame_ph;
  logic [1:0]            byte_idx;
  logic [ADDRESS_BITS:0] addr_cnt;
  logic [ADDRESS_BITS-1:0] end_addr;
  logic [7:0]            low_hold;

  assign fail_count = bad_words;
  assign pending    = due_cnt;

  task automatic flag_mismatch(input string what, input int want, input int got);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    bad_words++;
  endtask

  function automatic void push_cell(input logic b, input logic [7:0] rep, input seg_t seg);
    cell_t c;
    c.bit_value    = b;
    c.first_level  = b ? amp_low : amp_high;
    c.second_level = b ? amp_high : amp_low;
    c.repeat_count = rep;
    c.seg          = seg;
    c.last_in_run  = 1'b0;
    c.frame_done   = 1'b0;
    cells_due.push_back(c);
  endfunction

  // msb first
  function automatic void push_byte(input logic [7:0] b, input seg_t seg);
    for (int i = 7; i >= 0; i--) push_cell(b[i], 8'd1, seg);
  endfunction

  // 00 00 e6, then the checksum bytes follow
  function automatic void push_trailer();
    push_byte(TRAIL_BYTE0, SEG_TRAILER);
    push_byte(TRAIL_BYTE0, SEG_TRAILER);
    push_byte(TRAIL_BYTE2, SEG_TRAILER);
    frame_ph = PH_CHECK;
    byte_idx = 2'd0;
  endfunction

  function automatic void predict_cells(input logic op, input logic [7:0] b);
    int first_new;
    first_new = cells_due.size();
    if (op == OP_START) begin
      frame_ph = PH_HEADER;
      byte_idx = 2'd0;
      addr_cnt = '0;
      end_addr = '0;
      low_hold = 8'd0;
      if (pilot_len != 8'd0) push_cell(1'b0, pilot_len, SEG_PILOT);
    end else begin
      case (frame_ph)
        PH_HEADER: begin
          push_byte(b, SEG_HEADER);
          // start address low/high, end address low/high
          case (byte_idx)
            2'd1: begin
              addr_cnt = {1'b0, ADDRESS_BITS'({b, low_hold})};
              byte_idx = 2'd2;
            end
            2'd3: begin
              end_addr = ADDRESS_BITS'({b, low_hold});
              byte_idx = 2'd0;
              if (addr_cnt > end_addr) push_trailer();
              else frame_ph = PH_DATA;
            end
            default: begin
              low_hold = b;
              byte_idx = byte_idx + 2'd1;
            end
          endcase
        end
        PH_DATA: begin
          push_byte(b, SEG_DATA);
          addr_cnt = addr_cnt + 1'b1;
          if (addr_cnt > end_addr) push_trailer();
        end
        PH_CHECK: begin
          push_byte(b, SEG_CHECK);
          if (byte_idx == 2'd0) begin
            byte_idx = 2'd1;
          end else begin
            cells_due[cells_due.size()-1].frame_done = 1'b1;
            frame_ph = PH_IDLE;
            byte_idx = 2'd0;
          end
        end
        default: ;
      endcase
    end
    if (cells_due.size() > first_new) cells_due[cells_due.size()-1].last_in_run = 1'b1;
  endfunction

  task automatic check_cell();
    cell_t want;
    if (cells_due.size() == 0) begin
      flag_mismatch("cell word with nothing due", 0, out_tdata);
      return;
    end
    want = cells_due.pop_front();
    if (out_tdata[0] !== want.bit_value)
      flag_mismatch("bit_value", want.bit_value, out_tdata[0]);
    if (out_tdata[8:1] !== want.first_level)
      flag_mismatch("first_level", want.first_level, out_tdata[8:1]);
    if (out_tdata[16:9] !== want.second_level)
      flag_mismatch("second_level", want.second_level, out_tdata[16:9]);
    if (out_tdata[24:17] !== want.repeat_count)
      flag_mismatch("repeat_count", want.repeat_count, out_tdata[24:17]);
    if (out_tuser[2:0] !== want.seg)
      flag_mismatch("segment", want.seg, out_tuser[2:0]);
    if (out_tuser[3] !== want.frame_done)
      flag_mismatch("frame_done", want.frame_done, out_tuser[3]);
    if (out_tlast !== want.last_in_run)
      flag_mismatch("last_in_run", want.last_in_run, out_tlast);
  endtask

  // register writes, byte words and cell words as seen at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pilot_len   = PILOT_BITS_RST;
      amp_high    = HIGH_LEVEL_RST;
      amp_low     = LOW_LEVEL_RST;
      halfwave_us = HALFWAVE_RST;
      frame_ph    = PH_IDLE;
      byte_idx    = 2'd0;
      addr_cnt    = '0;
      end_addr    = '0;
      low_hold    = 8'd0;
      cells_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PILOT_BITS: pilot_len   = cfg_wdata[7:0];
          REG_HIGH_LEVEL: amp_high    = cfg_wdata[7:0];
          REG_LOW_LEVEL:  amp_low     = cfg_wdata[7:0];
          REG_HALFWAVE:   halfwave_us = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_cells(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_cell();
    end
    due_cnt <= cells_due.size();
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the biphase tape frame encoder with directed frames (register
// extremes, empty data run, counter past the top address, start while busy,
// bytes while idle) and then random frames with bursty input, a stalling
// receiver and register changes between drained phases.
// ----------------------------------------------------------------------------
module testbench;
  import biph_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_WORDS  = 385;
  localparam int HOLD_CYCLES   = 300;

  typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_TOGGLE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = OP_START;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_index = REG_PILOT_BITS;
  logic [15:0] cfg_wdata = 16'd0;

  int fail_count;
  int pending;
  int burst_left = 0;
  int words_sent = 0;
  int idle_words = 0;
  int unsigned cycle_cnt = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  biphase_tape_frame_encoder_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  biph_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d cells still due", cycle_cnt, pending);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: changing stall pattern, plus a long hold-off on request
  logic     hold_tog  = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode   = RX_FREE;

  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen  <= hold_tog;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FREE:  out_tready <= 1'b1;
        RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
        RX_SLOW:  out_tready <= ($urandom_range(0, 3) == 0);
        default:  out_tready <= ~out_tready;
      endcase
    end
  end

  // one byte word, sent in bursts with random gaps between them
  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // stop sending and wait until every predicted cell has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // all four registers, then one write to an index past them
  task automatic write_regs(input logic [7:0] pilot, input logic [7:0] hi,
                            input logic [7:0] lo, input logic [15:0] hw);
    cfg_write(REG_PILOT_BITS, {8'($urandom), pilot});
    cfg_write(REG_HIGH_LEVEL, {8'($urandom), hi});
    cfg_write(REG_LOW_LEVEL, {8'($urandom), lo});
    cfg_write(REG_HALFWAVE, hw);
    cfg_write(REG_HALFWAVE + 8'($urandom_range(1, 252)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_header(input logic [15:0] sa, input logic [15:0] ea);
    send_word(OP_BYTE, sa[7:0]);
    send_word(OP_BYTE, sa[15:8]);
    send_word(OP_BYTE, ea[7:0]);
    send_word(OP_BYTE, ea[15:8]);
  endtask

  // whole frame with random data and checksum, optionally cut short
  task automatic send_frame(input logic [15:0] sa, input logic [15:0] ea, input int cut);
    logic [7:0] hdr [4];
    int total;
    hdr[0] = sa[7:0];
    hdr[1] = sa[15:8];
    hdr[2] = ea[7:0];
    hdr[3] = ea[15:8];
    total = 7 + ((ea >= sa) ? (int'(ea) - int'(sa) + 1) : 0);
    for (int k = 0; k < total && k != cut; k++) begin
      if (k == 0) send_word(OP_START, 8'($urandom));
      else if (k < 5) send_word(OP_BYTE, hdr[k-1]);
      else send_word(OP_BYTE, 8'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_halfwave();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int sa_i;
    int ea_i;
    int len;
    int cut;
    int phase_words;
    int next_cfg;
    bit frame_open;
    bit hold_done;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values, two data bytes
    send_word(OP_START, 8'h00);
    send_header(16'h0010, 16'h0011);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'hA5);
    send_word(OP_BYTE, 8'h5A);
    // byte with no frame open is dropped
    send_word(OP_BYTE, 8'hFF);

    // no pilot, full-scale levels; start above end gives an empty data run
    drain();
    write_regs(8'h00, 8'hFF, 8'h00, 16'h0000);
    send_word(OP_START, 8'hFF);
    send_header(16'hFFFF, 16'h0000);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);

    // longest pilot; one byte at the top address pushes the counter past it
    drain();
    write_regs(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
    send_word(OP_START, 8'h5A);
    send_header(16'hFFFF, 16'hFFFF);
    send_word(OP_BYTE, 8'h80);
    send_word(OP_BYTE, 8'h01);
    // new frame while the checksum is still open
    send_word(OP_START, 8'h00);

    // random frames
    frame_open  = 1'b1;
    hold_done   = 1'b0;
    phase_words = 0;
    next_cfg    = 20;
    while (words_sent - idle_words < RANDOM_WORDS + 26) begin
      if (phase_words >= next_cfg) begin
        drain();
        write_regs(($urandom_range(0, 5) == 0) ? 8'h00 : pick_byte(),
                   pick_byte(), pick_byte(), pick_halfwave());
        phase_words = 0;
        next_cfg    = $urandom_range(30, 70);
        // long receiver hold-off while words keep coming
        if (!hold_done && words_sent > 150) begin
          hold_tog  <= ~hold_tog;
          hold_done = 1'b1;
        end
      end

      if (!frame_open && $urandom_range(0, 9) == 0) begin
        // stray bytes between frames
        repeat ($urandom_range(1, 3)) begin
          send_word(OP_BYTE, 8'($urandom));
          idle_words++;
        end
      end else begin
        case ($urandom_range(0, 5))
          0:       sa_i = $urandom_range(0, 3);
          1:       sa_i = $urandom_range(16'hFFF8, 16'hFFFF);
          default: sa_i = $urandom_range(0, 16'hFFFF);
        endcase
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        if (len == 0) begin
          if (sa_i == 0) sa_i = 1;
          ea_i = $urandom_range(0, sa_i - 1);
        end else begin
          ea_i = (sa_i + len - 1 > 16'hFFFF) ? 16'hFFFF : sa_i + len - 1;
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6 + len) : -1;
        send_frame(16'(sa_i), 16'(ea_i), cut);
        frame_open  = (cut >= 0);
        phase_words += (cut >= 0) ? cut : 7 + len;
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
